// ===== hw/rtl/bfd_pkg.sv =====
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared constants and types for the brace frame deframer.
// ----------------------------------------------------------------------------
package bfd_pkg;

  localparam logic [7:0] SOF_BYTE = 8'h7B;
  localparam logic [7:0] EOF_BYTE = 8'h7D;
  localparam logic [7:0] ESC_BYTE = 8'h5C;
  localparam logic [7:0] ESC_XOR  = 8'h20;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [1:0] ST_GOOD    = 2'd0;
  localparam logic [1:0] ST_BAD_SUM = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [1:0] frame_status;
    logic [7:0] payload_count;
  } bfd_result_t;

endpackage

// ===== hw/rtl/bfd_core.sv =====
// ----------------------------------------------------------------------------
// bfd_core
// Frame state and per-byte decode: unescape, sum, hold-back and end record.
// ----------------------------------------------------------------------------
module bfd_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          byte_in,
  output logic                res_vld,
  output bfd_pkg::bfd_result_t res
);
  import bfd_pkg::*;

  logic       in_frame;
  logic       escape_pending;
  logic [7:0] running_sum;
  logic [7:0] held_byte;
  logic       held_valid;
  logic [7:0] byte_count;

  logic       in_frame_next;
  logic       escape_pending_next;
  logic [7:0] running_sum_next;
  logic [7:0] held_byte_next;
  logic       held_valid_next;
  logic [7:0] byte_count_next;
  logic [7:0] unesc;

  assign unesc = escape_pending ? (byte_in ^ ESC_XOR) : byte_in;

  always_comb begin
    in_frame_next       = in_frame;
    escape_pending_next = escape_pending;
    running_sum_next    = running_sum;
    held_byte_next      = held_byte;
    held_valid_next     = held_valid;
    byte_count_next     = byte_count;
    res_vld             = 1'b0;
    res                 = '0;
    if (byte_in == SOF_BYTE) begin
      // An open brace always restarts, abandoning any frame in progress.
      in_frame_next       = 1'b1;
      escape_pending_next = 1'b0;
      running_sum_next    = '0;
      held_byte_next      = '0;
      held_valid_next     = 1'b0;
      byte_count_next     = '0;
    end else if (in_frame) begin
      if (byte_in == ESC_BYTE) begin
        escape_pending_next = 1'b1;
      end else if (byte_in == EOF_BYTE) begin
        res_vld           = 1'b1;
        res.kind          = KIND_END;
        res.payload_count = byte_count;
        if (running_sum != 8'd0) begin
          res.frame_status = ST_BAD_SUM;
        end else if (byte_count == 8'd0) begin
          res.frame_status = ST_EMPTY;
        end else begin
          res.frame_status = ST_GOOD;
        end
        in_frame_next       = 1'b0;
        escape_pending_next = 1'b0;
        running_sum_next    = '0;
        held_byte_next      = '0;
        held_valid_next     = 1'b0;
        byte_count_next     = '0;
      end else begin
        escape_pending_next = 1'b0;
        running_sum_next    = running_sum + unesc;
        held_byte_next      = unesc;
        held_valid_next     = 1'b1;
        // The byte held back is released only once a later byte shows it is
        // not the checksum.
        if (held_valid) begin
          res_vld          = 1'b1;
          res.kind         = KIND_DATA;
          res.payload_byte = held_byte;
          if (byte_count != COUNT_MAX) begin
            byte_count_next = byte_count + 8'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      escape_pending <= 1'b0;
      running_sum    <= '0;
      held_byte      <= '0;
      held_valid     <= 1'b0;
      byte_count     <= '0;
    end else if (fire) begin
      in_frame       <= in_frame_next;
      escape_pending <= escape_pending_next;
      running_sum    <= running_sum_next;
      held_byte      <= held_byte_next;
      held_valid     <= held_valid_next;
      byte_count     <= byte_count_next;
    end
  end

  a_held_in_frame: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> in_frame)
    else $error("held byte outside a frame");

  a_empty_zero_count: assert property (@(posedge clk) disable iff (rst)
    (fire && res_vld && res.kind == KIND_END && res.frame_status == ST_EMPTY)
      |-> (res.payload_count == 8'd0))
    else $error("empty frame with nonzero count");

  a_count_follows_release: assert property (@(posedge clk) disable iff (rst)
    (fire && res_vld && res.kind == KIND_DATA && byte_count != COUNT_MAX)
      |=> (byte_count == $past(byte_count) + 8'd1))
    else $error("payload count did not follow a released byte");

endmodule

// ===== hw/rtl/bfd_outbuf.sv =====
// ----------------------------------------------------------------------------
// bfd_outbuf
// Two-entry result register that decouples the core from downstream stall.
// ----------------------------------------------------------------------------
module bfd_outbuf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  bfd_pkg::bfd_result_t push_data,
  output logic                 room,
  output logic                 res_valid,
  input  logic                 res_stall,
  output bfd_pkg::bfd_result_t head
);
  import bfd_pkg::*;

  bfd_result_t slot0;
  bfd_result_t slot1;
  logic [1:0]  cnt;
  logic        pop;

  assign res_valid = (cnt != 2'd0);
  assign pop       = res_valid && !res_stall;
  assign head      = slot0;
  // Room depends on registered occupancy only, so upstream stall never sees
  // the downstream stall combinationally.
  assign room      = (cnt != 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  // A push never arrives while both entries are full.
  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && cnt == 2'd1) begin
        slot0 <= push_data;
      end else begin
        slot0 <= slot1;
      end
    end else if (push) begin
      if (cnt == 2'd0) begin
        slot0 <= push_data;
      end else begin
        slot1 <= push_data;
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3)
    else $error("result buffer occupancy out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && !pop) |-> !push)
    else $error("push into a full result buffer");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (cnt == $past(cnt) - 2'd1))
    else $error("occupancy did not drop after a transaction");

endmodule

// ===== hw/rtl/brace_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// brace_frame_deframer
// Byte-stuffed frame receiver with an additive checksum and end records.
// ----------------------------------------------------------------------------
// Path: an accepted byte is held in the input register until the result
//   buffer has room; its result, if any, is then decoded into that buffer.
// Throughput: one byte per cycle while the result buffer has room, set by the
//   single-pass decode between input register and two-entry result buffer.
// Reset clears frame state, the input valid flag and the result buffer occupancy.
module brace_frame_deframer (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  input  logic       res_stall,
  output logic       kind,
  output logic [7:0] payload_byte,
  output logic [1:0] frame_status,
  output logic [7:0] payload_count
);
  import bfd_pkg::*;

  logic        byte_vld;
  logic [7:0]  byte_q;
  logic        room;
  logic        fire;
  logic        core_vld;
  bfd_result_t core_res;
  bfd_result_t head;

  assign fire     = byte_vld && room;
  assign rx_stall = byte_vld && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_vld <= 1'b0;
    end else if (!rx_stall) begin
      byte_vld <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && !rx_stall) begin
      byte_q <= rx_byte;
    end
  end

  bfd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .byte_in (byte_q),
    .res_vld (core_vld),
    .res     (core_res)
  );

  bfd_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (fire && core_vld),
    .push_data (core_res),
    .room      (room),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .head      (head)
  );

  assign kind          = head.kind;
  assign payload_byte  = head.payload_byte;
  assign frame_status  = head.frame_status;
  assign payload_count = head.payload_count;

endmodule
